/* design/assert_macros.svh */
// assertion helpers used by the fader top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/rlsf_pkg.sv */
// ----------------------------------------------------------------------------
// rlsf_pkg
// Types and constants of the RGB LED slew-rate limited fader.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  // item codes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RED_MAX   = 2'd0,
    CFG_GREEN_MAX = 2'd1,
    CFG_BLUE_MAX  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [7:0]  MaxReset  = 8'd255;
  localparam logic [11:0] RateReset = 12'd50;

  // step = floor(rate * ms * 256 / 1000) = floor(32 * p / 125)
  // saturation point: p >= 65536 * 125 / 32
  localparam logic [27:0] StepSatProd = 28'd256000;
  localparam logic [15:0] StepSat     = 16'hFFFF;
  // ceil(2^30 / 125), exact for 32 * p below 2^23
  localparam logic [23:0] Recip125    = 24'd8589935;
  localparam int unsigned RecipShift  = 25;

  typedef struct packed {
    logic        func;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [11:0] fade_speed;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
  } out_item_t;

  // per-lane control from the pipeline sequencing
  typedef struct packed {
    logic adv;     // pipeline moves this cycle
    logic set_en;  // set-target item writes its goal
    logic tick_en; // tick item moves the level
  } lane_ctl_t;

endpackage

/* design/rgb_led_slew_fader_top.sv */
// Throughput: one item per cycle while no result is stalled; an accepted item
// passes the stage-one, stage-two and output registers. The three-stage
// pipeline (multiply, divide by reciprocal, slew) and the output register
// advance together. A stalled result freezes the whole pipeline and stalls
// the input. Reset sets levels and goals to zero, speed to 50, maxima to 255.
// ----------------------------------------------------------------------------
// rgb_led_slew_fader_top
// Three-lane RGB fader with a shared step unit and a merged output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_led_slew_fader_top import rlsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  logic [7:0] red_max_q;
  logic [7:0] green_max_q;
  logic [7:0] blue_max_q;
  logic       adv;
  logic       in_xfer;
  logic       v1_q;
  logic       func1_q;
  logic       v2_q;
  logic       func2_q;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  out_d;
  lane_ctl_t  ctl;
  logic [15:0] step;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= MaxReset;
      green_max_q <= MaxReset;
      blue_max_q  <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RED_MAX:   red_max_q   <= cfg_data_i;
        CFG_GREEN_MAX: green_max_q <= cfg_data_i;
        CFG_BLUE_MAX:  blue_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is held by the sink
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      func1_q     <= FUNC_SET;
      v2_q        <= 1'b0;
      func2_q     <= FUNC_SET;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      func1_q     <= in_data_i.func;
      v2_q        <= v1_q;
      func2_q     <= func1_q;
      out_valid_q <= v2_q;
    end
  end

  assign ctl.adv     = adv;
  assign ctl.set_en  = adv && v1_q && (func1_q == FUNC_SET);
  assign ctl.tick_en = adv && v2_q && (func2_q == FUNC_TICK);

  // shared step unit
  rlsf_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .rate_we_i    (in_xfer && (in_data_i.func == FUNC_SET)),
    .fade_speed_i (in_data_i.fade_speed),
    .elapsed_ms_i (in_data_i.elapsed_ms),
    .step_o       (step)
  );

  // color lanes
  rlsf_lane u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .level_i (in_data_i.red_level),
    .max_i   (red_max_q),
    .step_i  (step),
    .duty_o  (out_d.red_duty)
  );

  rlsf_lane u_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .level_i (in_data_i.green_level),
    .max_i   (green_max_q),
    .step_i  (step),
    .duty_o  (out_d.green_duty)
  );

  rlsf_lane u_blue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .level_i (in_data_i.blue_level),
    .max_i   (blue_max_q),
    .step_i  (step),
    .duty_o  (out_d.blue_duty)
  );

  // merged output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_held_result_stalls_input, out_valid_o && out_stall_i, in_stall_o)
  `ASSERT_NEXT(a_xfer_enters_stage_one, in_xfer, v1_q)
  `ASSERT_NEXT(a_stage_two_reaches_output, v2_q && adv, out_valid_o)

endmodule

/* design/rlsf_step.sv */
// ----------------------------------------------------------------------------
// rlsf_step
// Holds the fade speed and turns elapsed milliseconds into a saturated
// 8.8 step over two pipeline stages.
// ----------------------------------------------------------------------------
module rlsf_step import rlsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        rate_we_i,
  input  logic [11:0] fade_speed_i,
  input  logic [15:0] elapsed_ms_i,
  output logic [15:0] step_o
);

  logic [11:0] rate_q;
  logic [27:0] prod_q;
  logic [27:0] prod_d;
  logic [15:0] step_q;
  logic [15:0] step_d;
  logic [41:0] recip_prod;

  // fade speed, replaced by each set-target transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
    end else if (rate_we_i) begin
      rate_q <= fade_speed_i;
    end
  end

  // stage one: speed times elapsed
  assign prod_d = 28'(rate_q) * 28'(elapsed_ms_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  // stage two: divide 32p by 125 through the reciprocal, then saturate
  assign recip_prod = 42'(prod_q[17:0]) * 42'(Recip125);

  always_comb begin
    if (prod_q >= StepSatProd) begin
      step_d = StepSat;
    end else begin
      step_d = recip_prod[RecipShift +: 16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

/* design/rlsf_lane.sv */
// ----------------------------------------------------------------------------
// rlsf_lane
// One color channel: brightness-scaled goal and slew-limited 8.8 level.
// ----------------------------------------------------------------------------
module rlsf_lane import rlsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  logic [7:0]  level_i,
  input  logic [7:0]  max_i,
  input  logic [15:0] step_i,
  output logic [7:0]  duty_o
);

  logic [15:0] scaled_q;
  logic [15:0] goal_q;
  logic [15:0] goal_d;
  logic [15:0] now_q;
  logic [15:0] now_d;
  logic [16:0] quot_sum;
  logic [16:0] goal_sum;
  logic [15:0] diff;
  logic [15:0] slewed;

  // stage one: level times brightness maximum
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      scaled_q <= 16'(level_i) * 16'(max_i);
    end
  end

  // stage two: x * 256 / 255 = x + x / 255
  assign quot_sum = 17'(scaled_q) + 17'(scaled_q[15:8]) + 17'd1;
  assign goal_sum = 17'(scaled_q) + 17'(quot_sum[16:8]);
  assign goal_d   = goal_sum[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= '0;
    end else if (ctl_i.set_en) begin
      goal_q <= goal_d;
    end
  end

  // stage three: move toward the goal, snap when within one step
  always_comb begin
    if (goal_q > now_q) begin
      diff = goal_q - now_q;
    end else begin
      diff = now_q - goal_q;
    end
    if (now_q == goal_q) begin
      slewed = now_q;
    end else if (diff <= step_i) begin
      slewed = goal_q;
    end else if (goal_q > now_q) begin
      slewed = now_q + step_i;
    end else begin
      slewed = now_q - step_i;
    end
  end

  assign now_d = ctl_i.tick_en ? slewed : now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else begin
      now_q <= now_d;
    end
  end

  assign duty_o = now_d[15:8];

endmodule
